[hdl/pfl_pkg.sv]
// Shared constants and types for the Phong fragment lighting pipeline.
// No dependencies; used by pfl_norm and phong_fragment_lighting_top.
package pfl_pkg;

    localparam int SHININESS_LOG2_DEF = 5;
    localparam int NORM_LAT           = 37;
    localparam int CFG_IDX_W          = 3;
    localparam int CFG_DATA_W         = 48;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIGHT_DIR  = 3'd0,
        CFG_AMBIENT    = 3'd1,
        CFG_DIFFUSE    = 3'd2,
        CFG_SPECULAR   = 3'd3,
        CFG_VIEW_POS   = 3'd4
    } t_cfg_reg;

endpackage

[hdl/pfl_norm.sv]
// Pipelined vector normalizer: squares, bit-serial square root, restoring divide.
// Depends on pfl_pkg (latency constant).
module pfl_norm (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [16:0] i_vec [3],
    output logic signed [15:0] o_vec [3]
);

    localparam int SQ_STEPS  = 17;
    localparam int DIV_STEPS = 15;
    localparam int MP_LEN    = pfl_pkg::NORM_LAT - 1;
    localparam int NUM_TAP   = 3 + SQ_STEPS - 1;

    logic [16:0] r_mp      [MP_LEN][3];
    logic [31:0] r_sq      [3];
    logic [33:0] r_rad     [SQ_STEPS+1];
    logic [33:0] r_root    [SQ_STEPS+1];
    logic [33:0] w_trial   [SQ_STEPS];
    logic [30:0] r_rem     [DIV_STEPS+1][3];
    logic [14:0] r_quo     [DIV_STEPS+1][3];
    logic [16:0] r_den     [DIV_STEPS+1];
    logic [30:0] w_dsh     [DIV_STEPS];
    logic [15:0] w_abs     [3];
    logic [16:0] w_len;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_abs[i] = 16'(i_vec[i][16] ? -i_vec[i] : i_vec[i]);
        end
        for (int k = 0; k < SQ_STEPS; k++) begin
            w_trial[k] = r_root[k] + (34'(1) << (32 - 2 * k));
        end
        for (int j = 0; j < DIV_STEPS; j++) begin
            w_dsh[j] = 31'(r_den[j]) << (DIV_STEPS - 1 - j);
        end
        w_len = r_root[SQ_STEPS][16:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_mp[0][i] <= {i_vec[i][16], w_abs[i]};
                r_sq[i]    <= 32'(r_mp[0][i][15:0]) * 32'(r_mp[0][i][15:0]);
            end
            for (int k = 1; k < MP_LEN; k++) begin
                r_mp[k] <= r_mp[k-1];
            end
            r_rad[0]  <= 34'(r_sq[0]) + 34'(r_sq[1]) + 34'(r_sq[2]);
            r_root[0] <= '0;
            for (int k = 0; k < SQ_STEPS; k++) begin
                if (r_rad[k] >= w_trial[k]) begin
                    r_rad[k+1]  <= r_rad[k] - w_trial[k];
                    r_root[k+1] <= (r_root[k] >> 1) + (34'(1) << (32 - 2 * k));
                end else begin
                    r_rad[k+1]  <= r_rad[k];
                    r_root[k+1] <= r_root[k] >> 1;
                end
            end
            r_den[0] <= w_len;
            for (int i = 0; i < 3; i++) begin
                r_rem[0][i] <= (31'(r_mp[NUM_TAP][i][15:0]) << 14) + 31'(w_len[16:1]);
                r_quo[0][i] <= '0;
            end
            for (int j = 0; j < DIV_STEPS; j++) begin
                r_den[j+1] <= r_den[j];
                for (int i = 0; i < 3; i++) begin
                    if (r_rem[j][i] >= w_dsh[j]) begin
                        r_rem[j+1][i] <= r_rem[j][i] - w_dsh[j];
                        r_quo[j+1][i] <= {r_quo[j][i][13:0], 1'b1};
                    end else begin
                        r_rem[j+1][i] <= r_rem[j][i];
                        r_quo[j+1][i] <= {r_quo[j][i][13:0], 1'b0};
                    end
                end
            end
            for (int i = 0; i < 3; i++) begin
                if (r_den[DIV_STEPS] == '0) begin
                    o_vec[i] <= '0;
                end else if (r_mp[MP_LEN-1][i][16]) begin
                    o_vec[i] <= -$signed({1'b0, r_quo[DIV_STEPS][i]});
                end else begin
                    o_vec[i] <= $signed({1'b0, r_quo[DIV_STEPS][i]});
                end
            end
        end
    end

endmodule

[hdl/phong_fragment_lighting_top.sv]
// Top level of the Phong fragment lighting pipeline, one directional light.
// Depends on pfl_pkg and pfl_norm.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | i_in_valid, o_in_stall, normal/pos/texels | into block
//  out     | o_out_valid, i_out_stall, o_out_red/g/b   | out of block
//  cfg     | i_cfg_valid, o_cfg_ready, index, data     | into block
//
// One fragment per cycle while a valid result is not stalled.
// Synchronous active-low reset clears the valid line and the configuration registers.
// A stall on the result freezes the whole pipeline; the input stalls with it.
module phong_fragment_lighting_top #(
    parameter int SHININESS_LOG2 = pfl_pkg::SHININESS_LOG2_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [15:0]             i_normal_x,
    input  logic signed [15:0]             i_normal_y,
    input  logic signed [15:0]             i_normal_z,
    input  logic signed [15:0]             i_pos_x,
    input  logic signed [15:0]             i_pos_y,
    input  logic signed [15:0]             i_pos_z,
    input  logic [7:0]                     i_diff_tex_r,
    input  logic [7:0]                     i_diff_tex_g,
    input  logic [7:0]                     i_diff_tex_b,
    input  logic [7:0]                     i_spec_tex_r,
    input  logic [7:0]                     i_spec_tex_g,
    input  logic [7:0]                     i_spec_tex_b,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [7:0]                     o_out_red,
    output logic [7:0]                     o_out_green,
    output logic [7:0]                     o_out_blue,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pfl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pfl_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int S       = SHININESS_LOG2;
    localparam int TEX_DLY = pfl_pkg::NORM_LAT + 6 + S;
    localparam int DF_LEN  = 5 + S;
    localparam int LAT     = pfl_pkg::NORM_LAT + 9 + S;

    function automatic logic signed [39:0] rsh14(input logic signed [39:0] s);
        logic [39:0] m;
        m = s[39] ? 40'(-s) : 40'(s);
        m = (m + 40'd8192) >> 14;
        return s[39] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [14:0] clamp1(input logic signed [39:0] s);
        logic [14:0] c;
        if (s[39]) begin
            c = '0;
        end else if (s > 40'sd16384) begin
            c = 15'd16384;
        end else begin
            c = s[14:0];
        end
        return c;
    endfunction

    logic [pfl_pkg::CFG_DATA_W-1:0] r_light, r_amb, r_dif, r_spc, r_view;
    logic                           r_vld [LAT];
    logic                           w_en;

    logic signed [16:0] w_lraw [3];
    logic signed [16:0] w_nraw [3];
    logic signed [16:0] w_vraw [3];
    logic signed [15:0] w_l [3];
    logic signed [15:0] w_n [3];
    logic signed [15:0] w_v [3];
    logic signed [15:0] w_pos [3];
    logic signed [15:0] w_nin [3];

    logic [47:0]        r_tex [TEX_DLY];
    logic signed [31:0] r_nl [3];
    logic signed [15:0] r_n1 [3], r_l1 [3], r_v1 [3];
    logic signed [15:0] r_n2 [3], r_l2 [3], r_v2 [3];
    logic signed [15:0] r_l3 [3], r_v3 [3], r_v4 [3];
    logic signed [17:0] r_ndl;
    logic signed [34:0] r_rp [3];
    logic signed [18:0] r_r [3];
    logic signed [34:0] r_vr [3];
    logic [14:0]        r_dfl [DF_LEN];
    logic [14:0]        r_pw [S+1];
    logic [23:0]        r_at [3], r_dt [3], r_st [3], r_at2 [3];
    logic [14:0]        r_diff_c, r_spec_c;
    logic [38:0]        r_dterm [3], r_sterm [3];
    logic [7:0]         w_tex_d [3], w_tex_s [3];
    logic [40:0]        w_sum [3];
    logic [7:0]         w_out [3];
    logic signed [39:0] w_ndl_s, w_spec_s;

    assign w_en        = !(r_vld[LAT-1] && i_out_stall);
    assign o_in_stall  = !w_en;
    assign o_out_valid = r_vld[LAT-1];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light <= '0;
            r_amb   <= '0;
            r_dif   <= '0;
            r_spc   <= '0;
            r_view  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pfl_pkg::CFG_LIGHT_DIR: r_light <= i_cfg_data;
                pfl_pkg::CFG_AMBIENT:   r_amb   <= i_cfg_data;
                pfl_pkg::CFG_DIFFUSE:   r_dif   <= i_cfg_data;
                pfl_pkg::CFG_SPECULAR:  r_spc   <= i_cfg_data;
                pfl_pkg::CFG_VIEW_POS:  r_view  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_comb begin
        w_pos[0] = i_pos_x;
        w_pos[1] = i_pos_y;
        w_pos[2] = i_pos_z;
        w_nin[0] = i_normal_x;
        w_nin[1] = i_normal_y;
        w_nin[2] = i_normal_z;
        for (int i = 0; i < 3; i++) begin
            w_lraw[i] = -17'($signed(r_light[16*i +: 16]));
            w_nraw[i] = 17'(w_nin[i]);
            w_vraw[i] = 17'($signed(r_view[16*i +: 16])) - 17'(w_pos[i]);
        end
    end

    pfl_norm u_norm_l (.i_clk(i_clk), .i_en(w_en), .i_vec(w_lraw), .o_vec(w_l));
    pfl_norm u_norm_n (.i_clk(i_clk), .i_en(w_en), .i_vec(w_nraw), .o_vec(w_n));
    pfl_norm u_norm_v (.i_clk(i_clk), .i_en(w_en), .i_vec(w_vraw), .o_vec(w_v));

    always_comb begin
        w_ndl_s  = rsh14(40'(34'(r_nl[0]) + 34'(r_nl[1]) + 34'(r_nl[2])));
        w_spec_s = rsh14(40'(37'(r_vr[0]) + 37'(r_vr[1]) + 37'(r_vr[2])));
        for (int c = 0; c < 3; c++) begin
            w_tex_d[c] = r_tex[TEX_DLY-1][8*c +: 8];
            w_tex_s[c] = r_tex[TEX_DLY-1][24 + 8*c +: 8];
            w_sum[c]   = (41'(r_at2[c]) << 14) + 41'(r_dterm[c]) + 41'(r_sterm[c])
                         + (41'(1) << 27);
            w_out[c]   = (w_sum[c][40:28] > 13'd255) ? 8'd255 : w_sum[c][35:28];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tex[0] <= {i_spec_tex_b, i_spec_tex_g, i_spec_tex_r,
                         i_diff_tex_b, i_diff_tex_g, i_diff_tex_r};
            for (int k = 1; k < TEX_DLY; k++) begin
                r_tex[k] <= r_tex[k-1];
            end
            for (int i = 0; i < 3; i++) begin
                r_nl[i] <= w_n[i] * w_l[i];
                r_n1[i] <= w_n[i];
                r_l1[i] <= w_l[i];
                r_v1[i] <= w_v[i];
                r_n2[i] <= r_n1[i];
                r_l2[i] <= r_l1[i];
                r_v2[i] <= r_v1[i];
                r_rp[i] <= (35'(r_ndl) * 35'(r_n2[i])) <<< 1;
                r_l3[i] <= r_l2[i];
                r_v3[i] <= r_v2[i];
                r_r[i]  <= 19'(rsh14(40'(r_rp[i]))) - 19'(r_l3[i]);
                r_v4[i] <= r_v3[i];
                r_vr[i] <= 35'(r_v4[i]) * 35'(r_r[i]);
            end
            r_ndl    <= 18'(w_ndl_s);
            r_dfl[0] <= clamp1(w_ndl_s);
            for (int k = 1; k < DF_LEN; k++) begin
                r_dfl[k] <= r_dfl[k-1];
            end
            r_pw[0] <= clamp1(w_spec_s);
            for (int k = 0; k < S; k++) begin
                r_pw[k+1] <= 15'((30'(r_pw[k]) * 30'(r_pw[k]) + 30'd8192) >> 14);
            end
            r_diff_c <= r_dfl[DF_LEN-1];
            r_spec_c <= r_pw[S];
            for (int c = 0; c < 3; c++) begin
                r_at[c]     <= 24'(r_amb[16*c +: 16]) * 24'(w_tex_d[c]);
                r_dt[c]     <= 24'(r_dif[16*c +: 16]) * 24'(w_tex_d[c]);
                r_st[c]     <= 24'(r_spc[16*c +: 16]) * 24'(w_tex_s[c]);
                r_at2[c]    <= r_at[c];
                r_dterm[c]  <= 39'(r_dt[c]) * 39'(r_diff_c);
                r_sterm[c]  <= 39'(r_st[c]) * 39'(r_spec_c);
            end
            o_out_red   <= w_out[0];
            o_out_green <= w_out[1];
            o_out_blue  <= w_out[2];
        end
    end

endmodule

[tb/sv/pfl_checker.sv]
`timescale 1ns / 100ps
// Shading predictor and scoreboard for phong_fragment_lighting_top.
// Depends on pfl_pkg; snoops the cfg, in and out channels of the block.
module pfl_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic signed [15:0]             i_normal_x,
    input  logic signed [15:0]             i_normal_y,
    input  logic signed [15:0]             i_normal_z,
    input  logic signed [15:0]             i_pos_x,
    input  logic signed [15:0]             i_pos_y,
    input  logic signed [15:0]             i_pos_z,
    input  logic [7:0]                     i_diff_tex_r,
    input  logic [7:0]                     i_diff_tex_g,
    input  logic [7:0]                     i_diff_tex_b,
    input  logic [7:0]                     i_spec_tex_r,
    input  logic [7:0]                     i_spec_tex_g,
    input  logic [7:0]                     i_spec_tex_b,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [7:0]                     i_out_red,
    input  logic [7:0]                     i_out_green,
    input  logic [7:0]                     i_out_blue,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [pfl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pfl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);

    localparam int  FRAC = 14;
    localparam longint UNIT = 64'sd1 << FRAC;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    logic [47:0] light_dir_q, ambient_q, diffuse_q, specular_q, view_pos_q;
    t_pixel      expected_pixels[$];

    function automatic longint field_s(input logic [47:0] r, input int k);
        logic [15:0] f;
        f = r[16*k +: 16];
        return longint'($signed(f));
    endfunction

    function automatic longint round_frac(input longint s);
        longint half;
        half = 64'sd1 << (FRAC - 1);
        if (s >= 0) return (s + half) >>> FRAC;
        return -((-s + half) >>> FRAC);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic void to_unit(input longint a[3], output longint o[3]);
        longint unsigned s, len, m, q;
        s = 0;
        for (int i = 0; i < 3; i++) s += longint'(a[i] * a[i]);
        len = int_sqrt(s);
        for (int i = 0; i < 3; i++) begin
            if (len == 0) begin
                o[i] = 0;
            end else begin
                m = (a[i] < 0) ? -a[i] : a[i];
                q = ((m << FRAC) + len / 2) / len;
                o[i] = (a[i] < 0) ? -longint'(q) : longint'(q);
            end
        end
    endfunction

    function automatic longint clamp_unit(input longint v);
        return (v < 0) ? 0 : ((v > UNIT) ? UNIT : v);
    endfunction

    function automatic t_pixel shade_fragment(input longint nrm[3], input longint pos[3],
                                              input logic [7:0] dtex[3],
                                              input logic [7:0] stex[3]);
        longint raw[3], l[3], n[3], v[3], r[3];
        longint ndl, diff, spec;
        longint unsigned sum, o;
        logic [7:0] ch[3];
        for (int i = 0; i < 3; i++) raw[i] = -field_s(light_dir_q, i);
        to_unit(raw, l);
        to_unit(nrm, n);
        for (int i = 0; i < 3; i++) raw[i] = field_s(view_pos_q, i) - pos[i];
        to_unit(raw, v);
        ndl = round_frac(n[0] * l[0] + n[1] * l[1] + n[2] * l[2]);
        diff = clamp_unit(ndl);
        for (int i = 0; i < 3; i++) r[i] = -l[i] + round_frac(2 * ndl * n[i]);
        spec = clamp_unit(round_frac(v[0] * r[0] + v[1] * r[1] + v[2] * r[2]));
        for (int k = 0; k < pfl_pkg::SHININESS_LOG2_DEF; k++) spec = round_frac(spec * spec);
        for (int i = 0; i < 3; i++) begin
            sum = longint'(ambient_q[16*i +: 16]) * dtex[i] * UNIT
                + longint'(diffuse_q[16*i +: 16]) * dtex[i] * diff
                + longint'(specular_q[16*i +: 16]) * stex[i] * spec;
            o = (sum + (64'd1 << 27)) >> 28;
            ch[i] = (o > 255) ? 8'd255 : o[7:0];
        end
        return '{red: ch[0], green: ch[1], blue: ch[2]};
    endfunction

    assign o_pending = expected_pixels.size();

    always @(posedge i_clk) begin
        longint     nrm[3], pos[3];
        logic [7:0] dtex[3], stex[3];
        t_pixel     exp_px;
        int         errs;
        if (!i_rst_n) begin
            light_dir_q  <= '0;
            ambient_q    <= '0;
            diffuse_q    <= '0;
            specular_q   <= '0;
            view_pos_q   <= '0;
            o_fail_count <= 0;
        end else begin
            errs = 0;
            if (i_cfg_valid && i_cfg_ready) begin
                case (pfl_pkg::t_cfg_reg'(i_cfg_index))
                    pfl_pkg::CFG_LIGHT_DIR: light_dir_q <= i_cfg_data;
                    pfl_pkg::CFG_AMBIENT:   ambient_q   <= i_cfg_data;
                    pfl_pkg::CFG_DIFFUSE:   diffuse_q   <= i_cfg_data;
                    pfl_pkg::CFG_SPECULAR:  specular_q  <= i_cfg_data;
                    pfl_pkg::CFG_VIEW_POS:  view_pos_q  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                nrm  = '{i_normal_x, i_normal_y, i_normal_z};
                pos  = '{i_pos_x, i_pos_y, i_pos_z};
                dtex = '{i_diff_tex_r, i_diff_tex_g, i_diff_tex_b};
                stex = '{i_spec_tex_r, i_spec_tex_g, i_spec_tex_b};
                expected_pixels.push_back(shade_fragment(nrm, pos, dtex, stex));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected pixel %0d %0d %0d", i_out_red, i_out_green, i_out_blue);
                    errs = errs + 1;
                end else begin
                    exp_px = expected_pixels.pop_front();
                    if (exp_px.red !== i_out_red) begin
                        $error("out_red expected %0d actual %0d", exp_px.red, i_out_red);
                        errs = errs + 1;
                    end
                    if (exp_px.green !== i_out_green) begin
                        $error("out_green expected %0d actual %0d", exp_px.green, i_out_green);
                        errs = errs + 1;
                    end
                    if (exp_px.blue !== i_out_blue) begin
                        $error("out_blue expected %0d actual %0d", exp_px.blue, i_out_blue);
                        errs = errs + 1;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
        end
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Stimulus and verdict for phong_fragment_lighting_top.
// Depends on pfl_pkg, pfl_checker and phong_fragment_lighting_top.
module tb;

    localparam int LIMIT     = 400000;
    localparam int LATENCY   = pfl_pkg::NORM_LAT + pfl_pkg::SHININESS_LOG2_DEF + 9;
    localparam int PHASE_LEN = 560;
    localparam logic [pfl_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0, i_out_stall = 1'b0, i_cfg_valid = 1'b0;
    logic signed [15:0] i_normal_x = '0, i_normal_y = '0, i_normal_z = '0;
    logic signed [15:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic [7:0] i_diff_tex_r = '0, i_diff_tex_g = '0, i_diff_tex_b = '0;
    logic [7:0] i_spec_tex_r = '0, i_spec_tex_g = '0, i_spec_tex_b = '0;
    logic [pfl_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [pfl_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic o_in_stall, o_out_valid, o_cfg_ready;
    logic [7:0] o_out_red, o_out_green, o_out_blue;
    logic frag_taken = 1'b0, reg_taken = 1'b0;
    int   fail_count, pending, cycles = 0;
    int   send_idle = 0, recv_idle = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    phong_fragment_lighting_top u_top (.*);

    pfl_checker u_chk (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall),
        .i_normal_x, .i_normal_y, .i_normal_z, .i_pos_x, .i_pos_y, .i_pos_z,
        .i_diff_tex_r, .i_diff_tex_g, .i_diff_tex_b,
        .i_spec_tex_r, .i_spec_tex_g, .i_spec_tex_b,
        .i_out_valid(o_out_valid), .i_out_stall, .i_out_red(o_out_red),
        .i_out_green(o_out_green), .i_out_blue(o_out_blue),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        frag_taken <= i_in_valid && !o_in_stall;
        reg_taken  <= i_cfg_valid && o_cfg_ready;
        cycles     <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall = ($urandom_range(99) < recv_idle);
    end

    function automatic logic [47:0] pack3(input int x, input int y, input int z);
        logic [15:0] a, b, c;
        a = x[15:0];
        b = y[15:0];
        c = z[15:0];
        return {c, b, a};
    endfunction

    task automatic write_reg(input logic [pfl_pkg::CFG_IDX_W-1:0] idx, input logic [47:0] d);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = d;
        do @(negedge i_clk); while (!reg_taken);
        i_cfg_valid = 1'b0;
    endtask

    task automatic write_all(input logic [47:0] l, a, d, s, v);
        write_reg(pfl_pkg::CFG_LIGHT_DIR, l);
        write_reg(pfl_pkg::CFG_AMBIENT, a);
        write_reg(pfl_pkg::CFG_DIFFUSE, d);
        write_reg(pfl_pkg::CFG_SPECULAR, s);
        write_reg(pfl_pkg::CFG_VIEW_POS, v);
    endtask

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic send_frag(input int nx, ny, nz, px, py, pz,
                             input logic [47:0] tex);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_normal_x = nx[15:0];
        i_normal_y = ny[15:0];
        i_normal_z = nz[15:0];
        i_pos_x    = px[15:0];
        i_pos_y    = py[15:0];
        i_pos_z    = pz[15:0];
        {i_spec_tex_b, i_spec_tex_g, i_spec_tex_r,
         i_diff_tex_b, i_diff_tex_g, i_diff_tex_r} = tex;
        do @(negedge i_clk); while (!frag_taken);
        i_in_valid = 1'b0;
    endtask

    function automatic logic [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    function automatic int rand_s16();
        return $urandom_range(65535) - 32768;
    endfunction

    task automatic head_on_config();
        write_all(pack3(0, 0, -16384), pack3(1638, 2000, 900),
                  pack3(12000, 16384, 8000), pack3(16384, 20000, 65535),
                  pack3(0, 0, 2000));
    endtask

    task automatic random_frags(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(1)) begin
                send_frag($urandom_range(1600) - 800, $urandom_range(1600) - 800,
                          $urandom_range(32767 - 12000) + 12000,
                          $urandom_range(128) - 64, $urandom_range(128) - 64,
                          $urandom_range(1000) - 500, rand48());
            end else begin
                send_frag(rand_s16(), rand_s16(), rand_s16(),
                          rand_s16(), rand_s16(), rand_s16(), rand48());
            end
            if (i == count / 2 && $urandom_range(1)) drain();
        end
    endtask

    task automatic run_phase(input int s_idle, input int r_idle);
        send_idle = s_idle;
        recv_idle = r_idle;
        drain();
        head_on_config();
        random_frags(PHASE_LEN / 2);
        drain();
        write_all(rand48(), rand48(), rand48(), rand48(), rand48());
        random_frags(PHASE_LEN / 2);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // registers still at reset
        send_frag(16384, 0, 0, 0, 0, 0, {48{1'b1}});
        drain();
        head_on_config();
        send_frag(0, 0, 0, 0, 0, 0, {48{1'b1}});
        send_frag(0, 0, 16384, 0, 0, 2000 - 32, {48{1'b1}});
        send_frag(0, 0, 16384, 0, 0, 0, '0);
        send_frag(0, 0, -16384, 0, 0, 0, {48{1'b1}});
        send_frag(-32768, -32768, -32768, -32768, -32768, -32768, {48{1'b1}});
        send_frag(32767, 32767, 32767, 32767, 32767, 32767, {48{1'b1}});
        send_frag(0, 0, 32767, 0, 0, -32768, {24'hff00ff, 24'h00ff00});
        send_frag(300, -200, 16000, 5, -5, 100, 48'h80_40_20_10_08_04);
        send_frag(16384, 0, 16384, 0, 0, 2000, {48{1'b1}});
        drain();
        write_all(pack3(0, 0, 0), {48{1'b1}}, {48{1'b1}}, {48{1'b1}},
                  pack3(32767, -32768, 32767));
        send_frag(0, 0, 16384, 0, 0, 0, {48{1'b1}});
        send_frag(-32768, 32767, 0, -32768, 32767, 0, {48{1'b1}});
        send_frag(0, 0, 0, 32767, -32768, 32767, 48'h0102_0304_0506);
        drain();
        write_all({48{1'b1}}, '0, pack3(16384, 16384, 16384),
                  {48{1'b1}}, pack3(-32768, -32768, -32768));
        send_frag(1, 1, 1, 32767, 32767, 32767, {48{1'b1}});
        send_frag(-1, -1, -1, 0, 0, 0, {48{1'b1}});
        drain();
        write_reg(CFG_UNUSED, {48{1'b1}});
        send_frag(100, 100, 100, 0, 0, 0, {48{1'b1}});

        run_phase(26, 46);
        run_phase(46, 26);
        run_phase(0, 0);

        drain();
        repeat (LATENCY + 10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
